// ===== hw/rtl/planar_dead_reckoning_assert.svh =====
// Assertion macros shared by the dead reckoning RTL.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef PLANAR_DEAD_RECKONING_ASSERT_SVH
`define PLANAR_DEAD_RECKONING_ASSERT_SVH

`ifndef SYNTH
// cond implies prop in the same cycle
`define PDR_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("%m: check failed");
// cond implies prop in the next cycle
`define PDR_ASSERT_NXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("%m: check failed");
`else
`define PDR_ASSERT_IMP(label, cond, prop)
`define PDR_ASSERT_NXT(label, cond, prop)
`endif

`endif

// ===== hw/rtl/pdr_pkg.sv =====
// Package for the planar dead reckoning block: widths, constants, tables, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdr_pkg;

   localparam int STAMP_W           = 62;
   localparam int VEL_W             = 32;
   localparam int QUAT_W            = 32;
   localparam int TURN_W            = 32;
   localparam int DT_W              = 32;
   localparam int ANGLE_BITS_DEF    = 32;
   localparam int POSITION_BITS_DEF = 48;

   // CORDIC datapath
   localparam int CORDIC_STEPS = 30;
   localparam int IDX_W        = 5;
   localparam int CORDIC_W     = 34;
   localparam int ZETA_W       = 33;
   localparam logic [29:0] CORDIC_START = 30'd652032874;
   localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;

   // Bit-serial units
   localparam int SERIAL_W   = 64;
   localparam int SER_CNT_W  = 6;
   localparam int QUOT_W     = 35;
   localparam int REM_W      = 30;
   localparam logic [REM_W-1:0] NS_PER_S   = 30'd1000000000;
   localparam logic [63:0]      PHASE_GAIN = 64'd6304776848116587966;

   // Shared multiplier
   localparam int MOP_W  = 34;
   localparam int MPRD_W = 66;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINCOS_OLD,
      ST_MUL,
      ST_SERIAL,
      ST_UPDATE,
      ST_TURN,
      ST_SINCOS_NEW,
      ST_EMIT
   } pdr_state_type;

   typedef enum logic [2:0] {
      MS_VXC,
      MS_VYS,
      MS_VXS,
      MS_VYC,
      MS_RATE,
      MS_DX,
      MS_DY,
      MS_LAUNCH
   } pdr_mul_step_type;

   typedef struct packed {
      logic                     done;
      logic signed [QUAT_W-1:0] sin_q;
      logic signed [QUAT_W-1:0] cos_q;
   } pdr_sincos_type;

   // arctan(2^-i) in Q30
   function automatic logic [29:0] atan_q30(input logic [IDX_W-1:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:    val = 30'd843314857;
         5'd1:    val = 30'd497837829;
         5'd2:    val = 30'd263043837;
         5'd3:    val = 30'd133525159;
         5'd4:    val = 30'd67021687;
         5'd5:    val = 30'd33543516;
         5'd6:    val = 30'd16775851;
         5'd7:    val = 30'd8388437;
         5'd8:    val = 30'd4194283;
         5'd9:    val = 30'd2097149;
         5'd10:   val = 30'd1048576;
         5'd11:   val = 30'd524288;
         5'd12:   val = 30'd262144;
         5'd13:   val = 30'd131072;
         5'd14:   val = 30'd65536;
         5'd15:   val = 30'd32768;
         5'd16:   val = 30'd16384;
         5'd17:   val = 30'd8192;
         5'd18:   val = 30'd4096;
         5'd19:   val = 30'd2048;
         5'd20:   val = 30'd1024;
         5'd21:   val = 30'd512;
         5'd22:   val = 30'd256;
         5'd23:   val = 30'd128;
         5'd24:   val = 30'd64;
         5'd25:   val = 30'd32;
         5'd26:   val = 30'd16;
         5'd27:   val = 30'd8;
         5'd28:   val = 30'd4;
         5'd29:   val = 30'd2;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pdr_channels.sv =====
// Valid/ready channel interfaces for sample beats and pose beats.
// Depends on pdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pdr_req_if;
   logic                                valid;
   logic                                ready;
   logic [pdr_pkg::STAMP_W-1:0]         stamp_ns;
   logic signed [pdr_pkg::VEL_W-1:0]    vel_x;
   logic signed [pdr_pkg::VEL_W-1:0]    vel_y;
   logic signed [pdr_pkg::VEL_W-1:0]    yaw_rate;

   modport source (output valid, stamp_ns, vel_x, vel_y, yaw_rate, input ready);
   modport sink   (input valid, stamp_ns, vel_x, vel_y, yaw_rate, output ready);
endinterface

interface pdr_rsp_if #(
   parameter int POSITION_BITS = pdr_pkg::POSITION_BITS_DEF
);
   logic                                valid;
   logic                                ready;
   logic [pdr_pkg::STAMP_W-1:0]         out_stamp_ns;
   logic signed [POSITION_BITS-1:0]     pos_x;
   logic signed [POSITION_BITS-1:0]     pos_y;
   logic signed [pdr_pkg::QUAT_W-1:0]   quat_z;
   logic signed [pdr_pkg::QUAT_W-1:0]   quat_w;

   modport source (output valid, out_stamp_ns, pos_x, pos_y, quat_z, quat_w, input ready);
   modport sink   (input valid, out_stamp_ns, pos_x, pos_y, quat_z, quat_w, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pdr_cordic.sv =====
// Iterative CORDIC: sine and cosine of a 32-bit turn fraction, one rotation per cycle.
// Depends on pdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdr_cordic (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pdr_pkg::TURN_W-1:0]    turn,
   output pdr_pkg::pdr_sincos_type            result
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [pdr_pkg::IDX_W-1:0]            idx_ff, idx_in;
   logic [1:0]                           quad_ff, quad_in;
   logic signed [pdr_pkg::CORDIC_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [pdr_pkg::ZETA_W-1:0]    z_ff, z_in;
   logic signed [pdr_pkg::QUAT_W-1:0]    sin_ff, sin_in, cos_ff, cos_in;
   logic signed [pdr_pkg::CORDIC_W-1:0]  xs, ys;
   logic signed [pdr_pkg::ZETA_W-1:0]    ang;
   logic [60:0]                          zprod;
   logic                                 last;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      quad_ff <= quad_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
   end

   // load the angle on start, rotate once per cycle while busy
   always_comb begin
      zprod   = 61'(turn[29:0]) * 61'(pdr_pkg::HALF_PI_Q30);
      xs      = x_ff >>> idx_ff;
      ys      = y_ff >>> idx_ff;
      ang     = signed'({3'b000, pdr_pkg::atan_q30(idx_ff)});
      last    = busy_ff && (idx_ff == pdr_pkg::IDX_W'(pdr_pkg::CORDIC_STEPS - 1));
      busy_in = busy_ff;
      idx_in  = idx_ff;
      quad_in = quad_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         quad_in = turn[31:30];
         x_in    = signed'(pdr_pkg::CORDIC_W'(pdr_pkg::CORDIC_START));
         y_in    = '0;
         z_in    = signed'({2'b00, zprod[60:30]});
      end else if (busy_ff) begin
         if (!z_ff[pdr_pkg::ZETA_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end
         idx_in = idx_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   // fold the quadrant back in on the final rotation
   always_comb begin
      done_in = last;
      sin_in  = sin_ff;
      cos_in  = cos_ff;
      if (last) begin
         case (quad_ff)
            2'd0: begin
               sin_in = y_in[31:0];
               cos_in = x_in[31:0];
            end
            2'd1: begin
               sin_in = x_in[31:0];
               cos_in = 32'(-y_in);
            end
            2'd2: begin
               sin_in = 32'(-y_in);
               cos_in = 32'(-x_in);
            end
            default: begin
               sin_in = 32'(-x_in);
               cos_in = y_in[31:0];
            end
         endcase
      end
   end

   assign result.done  = done_ff;
   assign result.sin_q = sin_ff;
   assign result.cos_q = cos_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pdr_div_ns.sv =====
// Bit-serial restoring division of a 64-bit magnitude by one billion.
// Depends on pdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdr_div_ns (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pdr_pkg::SERIAL_W-1:0]  dividend,
   output logic                               done,
   output logic [pdr_pkg::QUOT_W-1:0]         quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [pdr_pkg::SER_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [pdr_pkg::SERIAL_W-1:0]       num_ff, num_in;
   logic [pdr_pkg::REM_W-1:0]          rem_ff, rem_in;
   logic [pdr_pkg::QUOT_W-1:0]         quo_ff, quo_in;
   logic [pdr_pkg::REM_W:0]            trial;
   logic                               qbit;
   logic                               last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // shift one dividend bit into the remainder, subtract when it fits
   always_comb begin
      trial   = {rem_ff, num_ff[pdr_pkg::SERIAL_W-1]};
      qbit    = (trial >= {1'b0, pdr_pkg::NS_PER_S});
      last    = busy_ff && (cnt_ff == pdr_pkg::SER_CNT_W'(pdr_pkg::SERIAL_W - 1));
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      done_in = last;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         num_in = {num_ff[pdr_pkg::SERIAL_W-2:0], 1'b0};
         rem_in = qbit ? pdr_pkg::REM_W'(trial - {1'b0, pdr_pkg::NS_PER_S})
                       : trial[pdr_pkg::REM_W-1:0];
         quo_in = {quo_ff[pdr_pkg::QUOT_W-2:0], qbit};
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pdr_phase_mul.sv =====
// Bit-serial shift-add multiply by the phase gain, keeping the upper 64 product bits.
// Depends on pdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdr_phase_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pdr_pkg::SERIAL_W-1:0]  mag,
   output logic                               done,
   output logic [pdr_pkg::SERIAL_W-1:0]       product_hi
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [pdr_pkg::SER_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [pdr_pkg::SERIAL_W-1:0]       mplr_ff, mplr_in;
   logic [pdr_pkg::SERIAL_W-1:0]       acc_ff, acc_in;
   logic [pdr_pkg::SERIAL_W:0]         sum;
   logic                               last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      mplr_ff <= mplr_in;
      acc_ff  <= acc_in;
   end

   // add the gain for the low multiplier bit, then drop one low bit
   always_comb begin
      sum     = {1'b0, acc_ff} + (mplr_ff[0] ? {1'b0, pdr_pkg::PHASE_GAIN}
                                              : {(pdr_pkg::SERIAL_W + 1){1'b0}});
      last    = busy_ff && (cnt_ff == pdr_pkg::SER_CNT_W'(pdr_pkg::SERIAL_W - 1));
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mplr_in = mplr_ff;
      acc_in  = acc_ff;
      done_in = last;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mplr_in = mag;
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff + 1'b1;
         mplr_in = {1'b0, mplr_ff[pdr_pkg::SERIAL_W-1:1]};
         acc_in  = sum[pdr_pkg::SERIAL_W:1];
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   assign done       = done_ff;
   assign product_hi = acc_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/planar_dead_reckoning.sv =====
// Top level of the planar dead reckoning block: sequencer, shared multiplier, pose state.
// Depends on pdr_pkg, pdr_channels, pdr_cordic, pdr_div_ns, pdr_phase_mul and the assert header.
//
// Integrates timestamped body velocity and yaw rate into a planar pose. The first
// beat after reset only zeroes the pose and records its stamp; it gives no pose
// beat. Every later beat runs through a 30-step CORDIC pass for the old heading, a
// sequence of products on one shared 34x34 multiplier, a bit-serial pass that
// divides both position steps by one billion and scales the heading step, and a
// second 30-step CORDIC pass for the new heading before the pose beat is loaded;
// the next sample beat is taken in the cycle after that. The pose beat sits in an
// output register, so a stalled consumer holds up the block only once the next
// pose is ready to load.
`timescale 1ns / 1ps
`default_nettype none
`include "planar_dead_reckoning_assert.svh"

module planar_dead_reckoning #(
   parameter int ANGLE_BITS    = pdr_pkg::ANGLE_BITS_DEF,
   parameter int POSITION_BITS = pdr_pkg::POSITION_BITS_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   pdr_req_if.sink     req_bus,
   pdr_rsp_if.source   rsp_bus
);

   localparam int PH_SHIFT = 48 - ANGLE_BITS;
   localparam int SUM_W    = ((POSITION_BITS > pdr_pkg::QUOT_W) ? POSITION_BITS
                                                                 : pdr_pkg::QUOT_W) + 2;
   localparam logic signed [SUM_W-1:0] POS_HI =
      {{(SUM_W - POSITION_BITS + 1){1'b0}}, {(POSITION_BITS - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] POS_LO =
      {{(SUM_W - POSITION_BITS + 1){1'b1}}, {(POSITION_BITS - 1){1'b0}}};

   // control
   pdr_pkg::pdr_state_type     state_ff, state_in;
   pdr_pkg::pdr_mul_step_type  mstep_ff, mstep_in;
   logic                       first_ff, first_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       req_ready_c, accept_c;
   logic                       cordic_start_c, serial_start_c, out_load_c;
   logic                       sincos_wait_c;

   // pose state and captured beat
   logic [pdr_pkg::STAMP_W-1:0]          last_stamp_ff, stamp_ff;
   logic [ANGLE_BITS-1:0]                phase_ff, phase_in;
   logic signed [POSITION_BITS-1:0]      acc_x_ff, acc_y_ff, sat_x, sat_y;
   logic signed [pdr_pkg::VEL_W-1:0]     vx_ff, vy_ff, rate_ff;
   logic signed [pdr_pkg::DT_W-1:0]      dt_ff, dt_c;
   logic signed [pdr_pkg::STAMP_W:0]     stamp_diff;

   // multiply sequence
   logic signed [pdr_pkg::MOP_W-1:0]     op_a, op_b, wx_abs, wy_abs, dt_abs, dt_ext;
   logic signed [2*pdr_pkg::MOP_W-1:0]   mul_full;
   logic signed [pdr_pkg::MPRD_W-1:0]    mul_ff, hold_ff, pdiff, psum;
   logic signed [pdr_pkg::MOP_W-1:0]     wx_ff, wy_ff;
   logic signed [pdr_pkg::SERIAL_W-1:0]  prod_ff;
   logic [pdr_pkg::SERIAL_W-1:0]         dvx_ff, prod_mag;

   // serial units and angle
   pdr_pkg::pdr_sincos_type              sc;
   logic [pdr_pkg::TURN_W-1:0]           turn_cur, cordic_turn;
   logic [63:0]                          ph_ext;
   logic                                 div_x_done, div_y_done, ph_done;
   logic [pdr_pkg::QUOT_W-1:0]           quot_x, quot_y;
   logic [pdr_pkg::SERIAL_W-1:0]         ph_hi, ph_step_full;
   logic [ANGLE_BITS-1:0]                ph_step;
   logic signed [SUM_W-1:0]              qx_s, qy_s, dx_s, dy_s, sx, sy;

   // output register
   logic [pdr_pkg::STAMP_W-1:0]          o_stamp_ff;
   logic signed [POSITION_BITS-1:0]      o_pos_x_ff, o_pos_y_ff;
   logic signed [pdr_pkg::QUAT_W-1:0]    o_qz_ff, o_qw_ff;

   pdr_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start_c),
      .turn   (cordic_turn),
      .result (sc)
   );

   pdr_div_ns u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (serial_start_c),
      .dividend (dvx_ff),
      .done     (div_x_done),
      .quotient (quot_x)
   );

   pdr_div_ns u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (serial_start_c),
      .dividend (mul_ff[pdr_pkg::SERIAL_W-1:0]),
      .done     (div_y_done),
      .quotient (quot_y)
   );

   pdr_phase_mul u_phase_mul (
      .clock      (clock),
      .reset      (reset),
      .start      (serial_start_c),
      .mag        (prod_mag),
      .done       (ph_done),
      .product_hi (ph_hi)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdr_pkg::ST_IDLE;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdr_pkg::ST_IDLE: begin
            if (accept_c && !first_ff) begin
               state_in = pdr_pkg::ST_SINCOS_OLD;
            end
         end
         pdr_pkg::ST_SINCOS_OLD: begin
            if (sc.done) begin
               state_in = pdr_pkg::ST_MUL;
            end
         end
         pdr_pkg::ST_MUL: begin
            if (mstep_ff == pdr_pkg::MS_LAUNCH) begin
               state_in = pdr_pkg::ST_SERIAL;
            end
         end
         pdr_pkg::ST_SERIAL: begin
            if (div_x_done) begin
               state_in = pdr_pkg::ST_UPDATE;
            end
         end
         pdr_pkg::ST_UPDATE:     state_in = pdr_pkg::ST_TURN;
         pdr_pkg::ST_TURN:       state_in = pdr_pkg::ST_SINCOS_NEW;
         pdr_pkg::ST_SINCOS_NEW: begin
            if (sc.done) begin
               state_in = pdr_pkg::ST_EMIT;
            end
         end
         pdr_pkg::ST_EMIT: begin
            if (out_load_c) begin
               state_in = pdr_pkg::ST_IDLE;
            end
         end
         default: state_in = pdr_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready_c    = 1'b0;
      cordic_start_c = 1'b0;
      serial_start_c = 1'b0;
      out_load_c     = 1'b0;
      case (state_ff)
         pdr_pkg::ST_IDLE: begin
            req_ready_c    = 1'b1;
            cordic_start_c = req_bus.valid && !first_ff;
         end
         pdr_pkg::ST_MUL:  serial_start_c = (mstep_ff == pdr_pkg::MS_LAUNCH);
         pdr_pkg::ST_TURN: cordic_start_c = 1'b1;
         pdr_pkg::ST_EMIT: out_load_c     = !rsp_valid_ff || rsp_bus.ready;
         default: begin
            req_ready_c = 1'b0;
         end
      endcase
   end

   assign accept_c      = req_bus.valid && req_ready_c;
   assign req_bus.ready = req_ready_c;
   assign first_in      = accept_c ? 1'b0 : first_ff;
   assign rsp_valid_in  = out_load_c | (rsp_valid_ff & ~rsp_bus.ready);

   // stamp difference saturated to 32 bits
   always_comb begin
      stamp_diff = signed'({1'b0, req_bus.stamp_ns}) - signed'({1'b0, last_stamp_ff});
      if ((&stamp_diff[pdr_pkg::STAMP_W:pdr_pkg::DT_W-1])
          || !(|stamp_diff[pdr_pkg::STAMP_W:pdr_pkg::DT_W-1])) begin
         dt_c = stamp_diff[pdr_pkg::DT_W-1:0];
      end else if (stamp_diff[pdr_pkg::STAMP_W]) begin
         dt_c = {1'b1, {(pdr_pkg::DT_W - 1){1'b0}}};
      end else begin
         dt_c = {1'b0, {(pdr_pkg::DT_W - 1){1'b1}}};
      end
   end

   // heading as a turn fraction; the old heading feeds the rotation doubled
   always_comb begin
      ph_ext      = 64'(phase_ff) << (64 - ANGLE_BITS);
      turn_cur    = ph_ext[63:32];
      cordic_turn = (state_ff == pdr_pkg::ST_IDLE) ? {turn_cur[30:0], 1'b0} : turn_cur;
   end

   // operand select for the shared multiplier
   always_comb begin
      dt_ext = pdr_pkg::MOP_W'(dt_ff);
      dt_abs = dt_ff[pdr_pkg::DT_W-1] ? -dt_ext : dt_ext;
      wx_abs = wx_ff[pdr_pkg::MOP_W-1] ? -wx_ff : wx_ff;
      wy_abs = wy_ff[pdr_pkg::MOP_W-1] ? -wy_ff : wy_ff;
      case (mstep_ff)
         pdr_pkg::MS_VXC: begin
            op_a = pdr_pkg::MOP_W'(vx_ff);
            op_b = pdr_pkg::MOP_W'(sc.cos_q);
         end
         pdr_pkg::MS_VYS: begin
            op_a = pdr_pkg::MOP_W'(vy_ff);
            op_b = pdr_pkg::MOP_W'(sc.sin_q);
         end
         pdr_pkg::MS_VXS: begin
            op_a = pdr_pkg::MOP_W'(vx_ff);
            op_b = pdr_pkg::MOP_W'(sc.sin_q);
         end
         pdr_pkg::MS_VYC: begin
            op_a = pdr_pkg::MOP_W'(vy_ff);
            op_b = pdr_pkg::MOP_W'(sc.cos_q);
         end
         pdr_pkg::MS_RATE: begin
            op_a = pdr_pkg::MOP_W'(rate_ff);
            op_b = dt_ext;
         end
         pdr_pkg::MS_DX: begin
            op_a = wx_abs;
            op_b = dt_abs;
         end
         pdr_pkg::MS_DY: begin
            op_a = wy_abs;
            op_b = dt_abs;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      mul_full = op_a * op_b;
      pdiff    = hold_ff - mul_ff;
      psum     = hold_ff + mul_ff;
   end

   // multiply step sequence
   always_comb begin
      mstep_in = mstep_ff;
      if (state_ff == pdr_pkg::ST_SINCOS_OLD) begin
         mstep_in = pdr_pkg::MS_VXC;
      end else if (state_ff == pdr_pkg::ST_MUL) begin
         case (mstep_ff)
            pdr_pkg::MS_VXC:  mstep_in = pdr_pkg::MS_VYS;
            pdr_pkg::MS_VYS:  mstep_in = pdr_pkg::MS_VXS;
            pdr_pkg::MS_VXS:  mstep_in = pdr_pkg::MS_VYC;
            pdr_pkg::MS_VYC:  mstep_in = pdr_pkg::MS_RATE;
            pdr_pkg::MS_RATE: mstep_in = pdr_pkg::MS_DX;
            pdr_pkg::MS_DX:   mstep_in = pdr_pkg::MS_DY;
            pdr_pkg::MS_DY:   mstep_in = pdr_pkg::MS_LAUNCH;
            default:          mstep_in = pdr_pkg::MS_LAUNCH;
         endcase
      end
   end

   // position and heading update
   always_comb begin
      prod_mag     = prod_ff[pdr_pkg::SERIAL_W-1] ? pdr_pkg::SERIAL_W'(-prod_ff)
                                                  : pdr_pkg::SERIAL_W'(prod_ff);
      ph_step_full = ph_hi >> PH_SHIFT;
      ph_step      = ph_step_full[ANGLE_BITS-1:0];
      phase_in     = prod_ff[pdr_pkg::SERIAL_W-1] ? (phase_ff - ph_step)
                                                  : (phase_ff + ph_step);
      qx_s = signed'(SUM_W'(quot_x));
      qy_s = signed'(SUM_W'(quot_y));
      dx_s = (wx_ff[pdr_pkg::MOP_W-1] ^ dt_ff[pdr_pkg::DT_W-1]) ? -qx_s : qx_s;
      dy_s = (wy_ff[pdr_pkg::MOP_W-1] ^ dt_ff[pdr_pkg::DT_W-1]) ? -qy_s : qy_s;
      sx   = SUM_W'(acc_x_ff) + dx_s;
      sy   = SUM_W'(acc_y_ff) + dy_s;
      if (sx > POS_HI) begin
         sat_x = POS_HI[POSITION_BITS-1:0];
      end else if (sx < POS_LO) begin
         sat_x = POS_LO[POSITION_BITS-1:0];
      end else begin
         sat_x = sx[POSITION_BITS-1:0];
      end
      if (sy > POS_HI) begin
         sat_y = POS_HI[POSITION_BITS-1:0];
      end else if (sy < POS_LO) begin
         sat_y = POS_LO[POSITION_BITS-1:0];
      end else begin
         sat_y = sy[POSITION_BITS-1:0];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mstep_ff <= mstep_in;
      // capture the beat; the first beat only zeroes the pose
      if (accept_c) begin
         last_stamp_ff <= req_bus.stamp_ns;
         stamp_ff      <= req_bus.stamp_ns;
         vx_ff         <= req_bus.vel_x;
         vy_ff         <= req_bus.vel_y;
         rate_ff       <= req_bus.yaw_rate;
         dt_ff         <= dt_c;
         if (first_ff) begin
            acc_x_ff <= '0;
            acc_y_ff <= '0;
            phase_ff <= '0;
         end
      end
      // products through the shared multiplier
      if (state_ff == pdr_pkg::ST_MUL) begin
         mul_ff <= mul_full[pdr_pkg::MPRD_W-1:0];
         case (mstep_ff)
            pdr_pkg::MS_VYS:  hold_ff <= mul_ff;
            pdr_pkg::MS_VXS:  wx_ff   <= pdiff[pdr_pkg::MOP_W+29:30];
            pdr_pkg::MS_VYC:  hold_ff <= mul_ff;
            pdr_pkg::MS_RATE: wy_ff   <= psum[pdr_pkg::MOP_W+29:30];
            pdr_pkg::MS_DX:   prod_ff <= mul_ff[pdr_pkg::SERIAL_W-1:0];
            pdr_pkg::MS_DY:   dvx_ff  <= mul_ff[pdr_pkg::SERIAL_W-1:0];
            default:          hold_ff <= hold_ff;
         endcase
      end
      if (state_ff == pdr_pkg::ST_UPDATE) begin
         acc_x_ff <= sat_x;
         acc_y_ff <= sat_y;
         phase_ff <= phase_in;
      end
      // load the pose beat
      if (out_load_c) begin
         o_stamp_ff <= stamp_ff;
         o_pos_x_ff <= acc_x_ff;
         o_pos_y_ff <= acc_y_ff;
         o_qz_ff    <= sc.sin_q;
         o_qw_ff    <= sc.cos_q;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_stamp_ns = o_stamp_ff;
   assign rsp_bus.pos_x        = o_pos_x_ff;
   assign rsp_bus.pos_y        = o_pos_y_ff;
   assign rsp_bus.quat_z       = o_qz_ff;
   assign rsp_bus.quat_w       = o_qw_ff;

   // CORDIC results are only expected in the two wait states
   assign sincos_wait_c = state_ff inside {pdr_pkg::ST_SINCOS_OLD, pdr_pkg::ST_SINCOS_NEW};

   `PDR_ASSERT_NXT(a_first_clears, accept_c && first_ff, !first_ff)
   `PDR_ASSERT_IMP(a_cordic_done_waited, sc.done, sincos_wait_c)
   `PDR_ASSERT_IMP(a_serial_in_step, div_x_done, (state_ff == pdr_pkg::ST_SERIAL) && div_y_done && ph_done)
   `PDR_ASSERT_NXT(a_load_shows_beat, out_load_c, rsp_valid_ff && (state_ff == pdr_pkg::ST_IDLE))

endmodule

`default_nettype wire
